### design/owfrm_pkg.sv
package owfrm_pkg;

    localparam int DEPTH   = 8;
    localparam int ID_W    = 16;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   item_id;
        logic [YEAR_W-1:0] year;
    } cmd_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  mean_year;
        logic [COUNT_W-1:0] count;
        logic               out_valid;
        logic [ID_W-1:0]    out_id;
        logic [YEAR_W-1:0]  out_year;
        logic               empty_error;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [YEAR_W-1:0] year;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

### design/owfrm_store.sv
module owfrm_store #(
    parameter int DEPTH = 8,
    parameter int PW    = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PW-1:0]     wr_addr,
    input  owfrm_pkg::entry_t wr_entry,
    input  logic [PW-1:0]     rd_addr,
    output owfrm_pkg::entry_t rd_entry
);
    import owfrm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    // write port at the tail
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // registered read of the head entry
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

### design/owfrm_div.sv
module owfrm_div #(
    parameter int SW = 16,
    parameter int CW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [SW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [SW-1:0] quotient
);
    import owfrm_pkg::*;

    localparam int NW = $clog2(SW + 1);

    logic          active_reg, active_next;
    logic          done_reg, done_next;
    logic [NW-1:0] step_reg, step_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [SW-1:0] quot_reg, quot_next;
    logic [CW-1:0] dvs_reg, dvs_next;
    logic [CW:0]   shifted;
    logic [CW:0]   diff;
    logic          fits;

    // one restoring step per cycle: shift in a dividend bit, trial subtract
    assign shifted = {rem_reg, quot_reg[SW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        dvs_next    = dvs_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = NW'(SW);
            rem_next    = '0;
            quot_next   = dividend;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next  = fits ? diff[CW-1:0] : shifted[CW-1:0];
            quot_next = {quot_reg[SW-2:0], fits};
            step_next = step_reg - NW'(1);
            if (step_reg == NW'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### design/overwrite_fifo_running_mean_unit.sv
// sequence: an accepted transaction passes the fifo update state, then the bit-serial
// mean divider with SW = 12 + clog2(DEPTH + 1), then the done state; the divider is
// skipped when the fifo ends empty; no new transaction is accepted until idle again;
// busy is high from the accepting edge until the strobe cycle ends; the result is shown
// for one cycle with done high, no stall
// reset clears pointers, count, running sum and the sequencer; entry storage is not cleared
module overwrite_fifo_running_mean_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  owfrm_pkg::cmd_t    cmd,
    output logic               done,
    output owfrm_pkg::result_t result
);
    import owfrm_pkg::*;

    // pointer, count and running sum widths all follow from the depth
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = YEAR_W + CW;

    state_t        state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    result_t       result_reg, result_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] sum_reg, sum_next;

    // fifo update terms, only meaningful in the update cycle
    logic          is_insert;
    logic          fifo_full;
    logic          fifo_empty;
    logic          do_pop;
    logic          do_push;
    logic [CW-1:0] cnt_upd;
    logic [SW-1:0] sum_upd;

    entry_t        head_entry;
    entry_t        wr_entry;
    logic          wr_en;
    logic          div_start;
    logic          div_done;
    logic [SW-1:0] div_quot;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        logic [PW-1:0] nxt;
        begin
            nxt = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
            return nxt;
        end
    endfunction

    // entry storage: the head is read on every cycle so that its entry is
    // registered and ready in the cycle after a transaction is accepted
    owfrm_store #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (tail_reg),
        .wr_entry (wr_entry),
        .rd_addr  (head_reg),
        .rd_entry (head_entry)
    );

    // bit-serial divider for the mean, loaded with the updated sum and count
    owfrm_div #(
        .SW (SW),
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_upd),
        .divisor  (cnt_upd),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign wr_entry = '{id: cmd_reg.item_id, year: cmd_reg.year};

    // an insert on a full fifo evicts the head first; the tail then equals
    // the old head, so the new entry lands where the evicted one was
    assign is_insert  = (cmd_reg.func == FUNC_INSERT);
    assign fifo_full  = (cnt_reg == CW'(DEPTH));
    assign fifo_empty = (cnt_reg == '0);
    assign do_push    = is_insert;
    assign do_pop     = is_insert ? fifo_full : !fifo_empty;

    always_comb
    begin
        cnt_upd = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_upd = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_upd = cnt_reg - CW'(1);
        end
    end

    // running sum replaces a walk over the held entries
    assign sum_upd = sum_reg
                   + (do_push ? SW'(cmd_reg.year) : '0)
                   - (do_pop  ? SW'(head_entry.year) : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = (cnt_upd != '0) ? ST_DIVIDE : ST_DONE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        cmd_next    = cmd_reg;
        result_next = result_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        wr_en       = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                end
            end
            ST_UPDATE:
            begin
                wr_en       = do_push;
                head_next   = do_pop  ? ptr_inc(head_reg) : head_reg;
                tail_next   = do_push ? ptr_inc(tail_reg) : tail_reg;
                cnt_next    = cnt_upd;
                sum_next    = sum_upd;
                div_start   = (cnt_upd != '0);
                result_next.mean_year   = '0;
                result_next.count       = COUNT_W'(cnt_upd);
                result_next.out_valid   = do_pop;
                result_next.out_id      = do_pop ? head_entry.id : '0;
                result_next.out_year    = do_pop ? head_entry.year : '0;
                result_next.empty_error = !is_insert && fifo_empty;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    // quotient never exceeds the largest year
                    result_next.mean_year = div_quot[YEAR_W-1:0];
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = result_reg;

endmodule

### design/owfrm_checker.sv
module owfrm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input owfrm_pkg::cmd_t    cmd,
    input logic               done,
    input owfrm_pkg::result_t result
);
    import owfrm_pkg::*;

    // an accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("unit not busy after accepting a transaction");

    // the strobe lasts one cycle and falls inside the busy window
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !done)
        else $error("done strobe not a single cycle inside busy");

    // an empty remove reports nothing and leaves an empty fifo
    a_empty_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.empty_error |->
            !result.out_valid && result.count == '0 && result.mean_year == '0)
        else $error("empty remove reported with inconsistent fields");

    // no removed entry means zero id and year
    a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.out_valid |-> result.out_id == '0 && result.out_year == '0)
        else $error("entry fields set without a removed entry");

    // an empty fifo has a zero mean
    a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.count == '0 |-> result.mean_year == '0)
        else $error("non-zero mean with no entries held");

endmodule

bind overwrite_fifo_running_mean_unit owfrm_checker u_owfrm_checker (.*);

### bench/overwrite_fifo_running_mean_unit_tb.sv
module overwrite_fifo_running_mean_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import owfrm_pkg::*;

    localparam int HEAD_W       = $clog2(DEPTH);
    localparam int SUM_W        = YEAR_W + $clog2(DEPTH + 1);
    // far longer than one dut transaction plus the longest sender gap, so this is generous
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    // shadow copy of the fifo, updated when a transaction is accepted
    logic [ID_W-1:0]    shadow_ids   [DEPTH];
    logic [YEAR_W-1:0]  shadow_years [DEPTH];
    logic [HEAD_W-1:0]  shadow_head  = '0;
    logic [COUNT_W-1:0] shadow_count = '0;
    logic [SUM_W-1:0]   shadow_sum   = '0;

    // results still owed by the dut, oldest first
    result_t pending_means[$];

    int mismatches  = 0;
    int idle_cycles = 0;

    overwrite_fifo_running_mean_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // apply one fifo operation to the shadow copy and return the result it should give
    function automatic result_t update_running_mean(cmd_t c);
        result_t           r;
        logic              evict;
        logic [HEAD_W-1:0] slot;
        r = '0;
        // an insert on a full fifo drops the head first, a remove pops it unless empty
        evict = (c.func == FUNC_INSERT) ? (shadow_count == COUNT_W'(DEPTH))
                                        : (shadow_count != '0);
        if (c.func == FUNC_REMOVE && shadow_count == '0)
            r.empty_error = 1'b1;
        if (evict)
        begin
            r.out_valid  = 1'b1;
            r.out_id     = shadow_ids[shadow_head];
            r.out_year   = shadow_years[shadow_head];
            shadow_sum   = shadow_sum - SUM_W'(shadow_years[shadow_head]);
            shadow_head  = HEAD_W'((int'(shadow_head) + 1) % DEPTH);
            shadow_count = shadow_count - 1'b1;
        end
        if (c.func == FUNC_INSERT)
        begin
            slot               = HEAD_W'((int'(shadow_head) + int'(shadow_count)) % DEPTH);
            shadow_ids[slot]   = c.item_id;
            shadow_years[slot] = c.year;
            shadow_sum         = shadow_sum + SUM_W'(c.year);
            shadow_count       = shadow_count + 1'b1;
        end
        r.count = shadow_count;
        if (shadow_count != '0)
            r.mean_year = YEAR_W'(shadow_sum / shadow_count);
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic func, logic [ID_W-1:0] id, logic [YEAR_W-1:0] yr);
        cmd_t c;
        c.func    = func;
        c.item_id = id;
        c.year    = yr;
        return c;
    endfunction

    // random operation; years lean towards the extremes now and then to stress the sum
    function automatic cmd_t random_cmd(int insert_pct);
        cmd_t c;
        int   pick;
        c.func    = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        c.item_id = ID_W'($urandom);
        pick      = $urandom_range(7);
        if (pick == 0)
            c.year = '0;
        else if (pick == 1)
            c.year = '1;
        else
            c.year = YEAR_W'($urandom);
        return c;
    endfunction

    // present one transaction and hold it until accepted; called and returns on a rising edge
    // start is left high so that a following transaction needs no second assignment
    task automatic send_cmd(cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        // busy only moves on a rising edge, so the mid-cycle value holds for the next edge
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        pending_means.push_back(update_running_mean(c));
    endtask

    // random sender gap, either straight after acceptance or once busy has dropped
    task automatic idle_burst();
        start <= 1'b0;
        if ($urandom_range(1) == 1)
        begin
            do
                @(negedge clk);
            while (busy);
            @(posedge clk);
        end
        repeat ($urandom_range(1, 3)) @(posedge clk);
    endtask

    task automatic maybe_idle(int idle_pct);
        if ($urandom_range(99) < idle_pct)
            idle_burst();
    endtask

    // corner cases: empty removes, extreme fields, full fifo with maximum sum, eviction, drain
    task automatic test_empty_and_full_edges();
        send_cmd(make_cmd(FUNC_REMOVE, '0, '0));
        send_cmd(make_cmd(FUNC_INSERT, '0, '0));
        send_cmd(make_cmd(FUNC_INSERT, '1, '1));
        // id and year of a remove are don't-care, drive them non-zero
        send_cmd(make_cmd(FUNC_REMOVE, 16'h5a5a, 12'ha5a));
        send_cmd(make_cmd(FUNC_REMOVE, '1, '1));
        send_cmd(make_cmd(FUNC_REMOVE, '1, '1));
        // fill with the largest year so the running sum reaches its largest possible value
        for (int i = 0; i < DEPTH; i++)
        begin
            send_cmd(make_cmd(FUNC_INSERT, ID_W'($urandom), '1));
            maybe_idle(30);
        end
        // inserts on a full fifo evict the oldest entry
        send_cmd(make_cmd(FUNC_INSERT, 16'h8001, 12'h001));
        send_cmd(make_cmd(FUNC_INSERT, 16'h7ffe, 12'h800));
        for (int i = 0; i < DEPTH; i++)
        begin
            send_cmd(make_cmd(FUNC_REMOVE, ID_W'($urandom), YEAR_W'($urandom)));
            maybe_idle(30);
        end
        send_cmd(make_cmd(FUNC_REMOVE, '0, '0));
    endtask

    // mixed traffic in phases with a drifting insert bias so every fill level is visited
    task automatic test_random_mix(int n_items);
        int insert_pct;
        int idle_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                insert_pct = $urandom_range(15, 85);
                // some phases run without gaps
                idle_pct   = ($urandom_range(3) == 0) ? 0 : 30;
            end
            send_cmd(random_cmd(insert_pct));
            maybe_idle(idle_pct);
        end
    endtask

    // fill past full so the pointers wrap, then drain past empty, with a little noise
    task automatic test_fill_drain(int rounds);
        for (int r = 0; r < rounds; r++)
        begin
            repeat ($urandom_range(DEPTH, 2 * DEPTH + 3))
            begin
                send_cmd(random_cmd(90));
                maybe_idle(25);
            end
            repeat ($urandom_range(DEPTH, DEPTH + 3))
            begin
                send_cmd(random_cmd(10));
                maybe_idle(25);
            end
        end
    endtask

    // closing stretch with start held high throughout
    task automatic test_back_to_back(int n_items);
        for (int i = 0; i < n_items; i++)
            send_cmd(random_cmd(55));
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // results are sampled mid-cycle, well clear of the edge that moves them
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_means.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_means.pop_front();
                check_field("mean_year",   32'(want.mean_year),   32'(result.mean_year));
                check_field("count",       32'(want.count),       32'(result.count));
                check_field("out_valid",   32'(want.out_valid),   32'(result.out_valid));
                check_field("out_id",      32'(want.out_id),      32'(result.out_id));
                check_field("out_year",    32'(want.out_year),    32'(result.out_year));
                check_field("empty_error", 32'(want.empty_error), 32'(result.empty_error));
            end
        end
    end

    // watchdog: too long without a transaction accepted in either direction
    always @(negedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $time, pending_means.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_full_edges();
        test_random_mix(400);
        test_fill_drain(12);
        test_back_to_back(100);

        start <= 1'b0;
        // the watchdog bounds this wait
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
